@@ src/pfc_pkg.sv @@
package pfc_pkg;

  // Framing characters.
  localparam logic [7:0] DLE_BYTE = 8'h10;
  localparam logic [7:0] STX_BYTE = 8'h02;
  localparam logic [7:0] ETX_BYTE = 8'h03;

  // CRC-8 generator polynomial and the top bit used for feedback.
  localparam logic [7:0] CRC_POLY = 8'b0000_0111;
  localparam logic [7:0] CRC_TOP  = 8'h80;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_PACKET_TYPE = 1'b0,
    REG_MAX_LENGTH  = 1'b1
  } reg_index_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_NO_ROOM     = 2'd1,
    STAT_NO_ROOM_DLE = 2'd2
  } status_t;

  // One queued input beat.
  typedef struct packed {
    logic [7:0] data;
    logic       sop;
    logic       eop;
  } q_item_t;

  // Steps of the framing sequencer. The _DUP steps send the stuffed second DLE.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DLE1,
    ST_STX,
    ST_TYPE,
    ST_TYPE_DUP,
    ST_DATA,
    ST_DATA_DUP,
    ST_CRC,
    ST_CRC_DUP,
    ST_DLE2,
    ST_ETX
  } eng_state_t;

  // One byte through the CRC-8, most significant bit first.
  function automatic logic [7:0] crc8_add(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = ((c & CRC_TOP) != 8'd0) ^ b[i];
      c  = {c[6:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

@@ src/dle_stx_packet_framer_crc8.sv @@
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   data_byte, start_of_packet, end_of_packet
// output    out        out_valid / out_stall out_byte, run_last, frame_done, status
// config    in         cfg_we (no wait)      cfg_addr, cfg_data
//
// An item leaves the two-entry input queue only while the sequencer is idle,
// and the sequencer then sends its result beats before it takes the next. An
// opening item sends up to six beats, a closing one up to six, and one that
// both opens and closes up to ten.
// The framing sequencer sends at most one beat per cycle, which sets the rate.
// Synchronous active-high reset clears the queue, sequencer and packet state,
// sets packet_type to 0 and max_length to 255.
// in_stall rises only when the queue is full; out_stall holds the result register.
module dle_stx_packet_framer_crc8 (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_addr,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       start_of_packet,
  input  logic       end_of_packet,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       frame_done,
  output logic [1:0] status
);
  import pfc_pkg::*;

  logic [7:0] packet_type;
  logic [7:0] max_length;
  q_item_t    in_item;
  q_item_t    q_item;
  logic       q_valid;
  logic       q_pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      packet_type <= 8'd0;
      max_length  <= 8'd255;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_addr))
        REG_PACKET_TYPE: packet_type <= cfg_data;
        REG_MAX_LENGTH:  max_length  <= cfg_data;
        default:         packet_type <= packet_type;
      endcase
    end
  end

  // Input beat packed for the queue.
  assign in_item = '{data: data_byte, sop: start_of_packet, eop: end_of_packet};

  pfc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  pfc_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .packet_type (packet_type),
    .max_length  (max_length),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_item      (q_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .frame_done  (frame_done),
    .status      (status)
  );

endmodule

@@ src/pfc_queue.sv @@
module pfc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  pfc_pkg::q_item_t in_item,
  output logic             q_valid,
  input  logic             q_pop,
  output pfc_pkg::q_item_t q_item
);
  import pfc_pkg::*;

  // Two-entry queue between the input side and the framing sequencer.
  q_item_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  // Stall only depends on the fill level, never on the incoming valid.
  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (count != 2'd0);
  assign q_item   = entries[rd_ptr];

  // Entry storage; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_item;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // A pop never happens on an empty queue.
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");

  // The fill level never exceeds the depth.
  assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue fill level out of range");

  // A push into a non-full queue raises the level unless a pop matches it.
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 2'd1))
    else $error("queue level did not follow a push");
`endif

endmodule

@@ src/pfc_engine.sv @@
module pfc_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       packet_type,
  input  logic [7:0]       max_length,
  input  logic             q_valid,
  output logic             q_pop,
  input  pfc_pkg::q_item_t q_item,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             run_last,
  output logic             frame_done,
  output logic [1:0]       status
);
  import pfc_pkg::*;

  eng_state_t state, state_next;

  // Packet state.
  logic [7:0] crc_reg, crc_reg_next;
  logic [7:0] byte_count, byte_count_next;
  logic       in_packet, in_packet_next;
  logic       dropping, dropping_next;

  // Item being framed.
  logic [7:0] cur_data, cur_data_next;
  logic       cur_eop, cur_eop_next;

  // Result register.
  logic       out_valid_next;
  logic [7:0] out_byte_next;
  logic       run_last_next;
  logic       frame_done_next;
  status_t    status_next;

  // Step decode.
  logic       load;
  logic [7:0] step_byte;
  logic       step_stuff;
  logic       step_crc;
  logic       step_dup;
  eng_state_t dup_state;
  eng_state_t follow;
  logic       is_dle;
  logic       room_one;
  logic       room_two;

  // The result register can take a new beat when empty or being taken.
  assign load     = !out_valid || !out_stall;
  assign is_dle   = (step_byte == DLE_BYTE);
  assign room_one = (byte_count < max_length);
  assign room_two = (({1'b0, byte_count} + 9'd1) < {1'b0, max_length});

  // Byte, stuffing and follow-on step for every sequencer state.
  always_comb begin
    step_byte  = DLE_BYTE;
    step_stuff = 1'b0;
    step_crc   = 1'b0;
    step_dup   = 1'b0;
    dup_state  = ST_IDLE;
    follow     = ST_IDLE;
    unique case (state)
      ST_IDLE: begin
        follow = ST_IDLE;
      end
      ST_DLE1: begin
        follow = ST_STX;
      end
      ST_STX: begin
        step_byte = STX_BYTE;
        follow    = ST_TYPE;
      end
      ST_TYPE: begin
        step_byte  = packet_type;
        step_stuff = 1'b1;
        step_crc   = 1'b1;
        dup_state  = ST_TYPE_DUP;
        follow     = ST_DATA;
      end
      ST_TYPE_DUP: begin
        step_dup = 1'b1;
        follow   = ST_DATA;
      end
      ST_DATA: begin
        step_byte  = cur_data;
        step_stuff = 1'b1;
        step_crc   = 1'b1;
        dup_state  = ST_DATA_DUP;
        follow     = cur_eop ? ST_CRC : ST_IDLE;
      end
      ST_DATA_DUP: begin
        step_dup = 1'b1;
        follow   = cur_eop ? ST_CRC : ST_IDLE;
      end
      ST_CRC: begin
        step_byte  = crc_reg;
        step_stuff = 1'b1;
        dup_state  = ST_CRC_DUP;
        follow     = ST_DLE2;
      end
      ST_CRC_DUP: begin
        step_dup = 1'b1;
        follow   = ST_DLE2;
      end
      ST_DLE2: begin
        follow = ST_ETX;
      end
      ST_ETX: begin
        step_byte = ETX_BYTE;
        follow    = ST_IDLE;
      end
      default: begin
        follow = ST_IDLE;
      end
    endcase
  end

  // Next state, packet state and result beat.
  always_comb begin
    state_next      = state;
    crc_reg_next    = crc_reg;
    byte_count_next = byte_count;
    in_packet_next  = in_packet;
    dropping_next   = dropping;
    cur_data_next   = cur_data;
    cur_eop_next    = cur_eop;
    q_pop           = 1'b0;
    out_valid_next  = load ? 1'b0 : out_valid;
    out_byte_next   = out_byte;
    run_last_next   = run_last;
    frame_done_next = frame_done;
    status_next     = status_t'(status);

    if (state == ST_IDLE) begin
      // Take the next item and decide whether it opens, continues or is ignored.
      if (q_valid) begin
        q_pop         = 1'b1;
        cur_data_next = q_item.data;
        cur_eop_next  = q_item.eop;
        if (q_item.sop) begin
          crc_reg_next    = 8'd0;
          byte_count_next = 8'd0;
          in_packet_next  = 1'b1;
          dropping_next   = 1'b0;
          state_next      = ST_DLE1;
        end else if (in_packet && !dropping) begin
          state_next = ST_DATA;
        end else if (q_item.eop) begin
          in_packet_next = 1'b0;
          dropping_next  = 1'b0;
        end
      end
    end else if (load) begin
      out_valid_next  = 1'b1;
      frame_done_next = 1'b0;
      if (step_dup) begin
        // Second copy of a stuffed DLE; room was checked with the first.
        out_byte_next   = DLE_BYTE;
        status_next     = STAT_OK;
        byte_count_next = byte_count + 8'd1;
        state_next      = follow;
      end else if (!room_one) begin
        out_byte_next = 8'd0;
        status_next   = STAT_NO_ROOM;
        dropping_next = 1'b1;
        state_next    = ST_IDLE;
      end else if (step_stuff && is_dle && !room_two) begin
        out_byte_next = 8'd0;
        status_next   = STAT_NO_ROOM_DLE;
        dropping_next = 1'b1;
        state_next    = ST_IDLE;
      end else begin
        out_byte_next   = step_byte;
        status_next     = STAT_OK;
        frame_done_next = (state == ST_ETX);
        byte_count_next = byte_count + 8'd1;
        if (step_crc) begin
          crc_reg_next = crc8_add(crc_reg, step_byte);
        end
        state_next = (step_stuff && is_dle) ? dup_state : follow;
      end
      // The item ends here; an end flag closes the packet, dropped or not.
      run_last_next = (state_next == ST_IDLE);
      if (state_next == ST_IDLE && cur_eop) begin
        in_packet_next = 1'b0;
        dropping_next  = 1'b0;
      end
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Packet control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg    <= 8'd0;
      byte_count <= 8'd0;
      in_packet  <= 1'b0;
      dropping   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      crc_reg    <= crc_reg_next;
      byte_count <= byte_count_next;
      in_packet  <= in_packet_next;
      dropping   <= dropping_next;
      out_valid  <= out_valid_next;
    end
  end

  // Item and result payload.
  always_ff @(posedge clk) begin
    cur_data   <= cur_data_next;
    cur_eop    <= cur_eop_next;
    out_byte   <= out_byte_next;
    run_last   <= run_last_next;
    frame_done <= frame_done_next;
    status     <= status_next;
  end

`ifndef ASSERT_OFF
  // An error beat carries a zero byte and ends its item.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STAT_OK) |-> (out_byte == 8'd0 && run_last && !frame_done))
    else $error("malformed error beat");

  // The closing beat is an ETX that ends its item without error.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_done) |-> (out_byte == ETX_BYTE && run_last && status == STAT_OK))
    else $error("malformed closing beat");

  // While a packet is being framed it is open and not being dropped.
  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (in_packet && !dropping))
    else $error("framing outside an open packet");

  // A new item is only taken while the sequencer is idle.
  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == ST_IDLE && q_valid))
    else $error("item taken while busy");

  // A stuffed copy always follows a DLE that was just sent.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_TYPE_DUP || state == ST_DATA_DUP || state == ST_CRC_DUP)
      |-> (out_valid && out_byte == DLE_BYTE))
    else $error("stuffing step without a preceding DLE");
`endif

endmodule

@@ tb/frame_checker.sv @@
`timescale 1ns / 100ps

module frame_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_addr,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       start_of_packet,
  input  logic       end_of_packet,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       run_last,
  input  logic       frame_done,
  input  logic [1:0] status,
  output int         pending,
  output int         mismatches,
  output int         bytes_checked
);
  import pfc_pkg::*;

  // One framed line beat as it should leave the block.
  typedef struct packed {
    logic [7:0] line_byte;
    logic       last;
    logic       done;
    status_t    stat;
  } line_beat_t;

  // Line beats predicted but not yet seen, oldest first.
  line_beat_t bytes_due[$];

  // Mirror of the registers and of the packet state.
  logic [7:0] type_reg;
  logic [7:0] limit_reg;
  logic [7:0] crc_acc;
  logic [7:0] sent;
  logic       open_pkt;
  logic       discarding;
  int         n_bad = 0;
  int         n_checked = 0;

  // CRC-8, polynomial 0x07, most significant bit first: fold the byte in, then
  // shift out eight bits.
  function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic void owe_beat(input logic [7:0] b, input logic done, input status_t st);
    line_beat_t r;
    r.line_byte = b;
    r.last      = 1'b0;
    r.done      = done;
    r.stat      = st;
    bytes_due.push_back(r);
  endfunction

  // Places one byte on the line if it fits within the length limit, together
  // with a stuffed copy if it is a DLE and stuffing is on. Returns 0 on overflow.
  function automatic bit put_line_byte(input logic [7:0] b, input bit in_crc,
                                       input bit stuffed, input bit closing);
    bit twin;
    twin = stuffed && (b == DLE_BYTE);
    if (sent >= limit_reg) begin
      owe_beat(8'h00, 1'b0, STAT_NO_ROOM);
      discarding = 1'b1;
      return 1'b0;
    end
    if (twin && (int'(sent) + 1 >= int'(limit_reg))) begin
      owe_beat(8'h00, 1'b0, STAT_NO_ROOM_DLE);
      discarding = 1'b1;
      return 1'b0;
    end
    if (in_crc) begin
      crc_acc = crc_step(crc_acc, b);
    end
    owe_beat(b, closing, STAT_OK);
    sent = sent + 8'd1;
    if (twin) begin
      owe_beat(DLE_BYTE, 1'b0, STAT_OK);
      sent = sent + 8'd1;
    end
    return 1'b1;
  endfunction

  // Works out the line beats that one accepted payload beat causes.
  function automatic void frame_beat(input logic [7:0] d, input bit sop, input bit eop);
    int         first;
    bit         ok;
    line_beat_t tail;
    first = bytes_due.size();
    ok = 1'b1;
    if (sop) begin
      crc_acc    = 8'h00;
      sent       = 8'h00;
      open_pkt   = 1'b1;
      discarding = 1'b0;
      ok = put_line_byte(DLE_BYTE, 1'b0, 1'b0, 1'b0);
      if (ok) ok = put_line_byte(STX_BYTE, 1'b0, 1'b0, 1'b0);
      if (ok) ok = put_line_byte(type_reg, 1'b1, 1'b1, 1'b0);
    end
    if (open_pkt && !discarding && ok) begin
      ok = put_line_byte(d, 1'b1, 1'b1, 1'b0);
      if (ok && eop) begin
        ok = put_line_byte(crc_acc, 1'b0, 1'b1, 1'b0);
        if (ok) ok = put_line_byte(DLE_BYTE, 1'b0, 1'b0, 1'b0);
        if (ok) ok = put_line_byte(ETX_BYTE, 1'b0, 1'b0, 1'b1);
      end
    end
    if (eop) begin
      open_pkt   = 1'b0;
      discarding = 1'b0;
    end
    if (bytes_due.size() > first) begin
      tail = bytes_due.pop_back();
      tail.last = 1'b1;
      bytes_due.push_back(tail);
    end
  endfunction

  // Output beats are compared before a new payload beat is predicted, so a
  // result can never be matched against the beat accepted on the same edge.
  always @(posedge clk) begin
    line_beat_t want;
    if (rst) begin
      bytes_due.delete();
      type_reg   = 8'h00;
      limit_reg  = 8'd255;
      crc_acc    = 8'h00;
      sent       = 8'h00;
      open_pkt   = 1'b0;
      discarding = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_checked++;
        if (bytes_due.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("%0t: line beat with nothing due: byte %h last %b done %b status %0d",
                     $realtime, out_byte, run_last, frame_done, status);
          end
        end else begin
          want = bytes_due.pop_front();
          if (out_byte !== want.line_byte || run_last !== want.last ||
              frame_done !== want.done || status !== want.stat) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("%0t: line beat differs: byte %h/%h last %b/%b done %b/%b status %0d/%0d",
                       $realtime, want.line_byte, out_byte, want.last, run_last,
                       want.done, frame_done, want.stat, status);
              $display("  (each pair is expected/actual)");
            end
          end
        end
      end
      if (cfg_we) begin
        case (reg_index_t'(cfg_addr))
          REG_PACKET_TYPE: type_reg = cfg_data;
          REG_MAX_LENGTH:  limit_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        frame_beat(data_byte, start_of_packet, end_of_packet);
      end
    end
    pending       <= bytes_due.size();
    mismatches    <= n_bad;
    bytes_checked <= n_checked;
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import pfc_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 24;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [0:0] cfg_addr;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] data_byte;
  logic       start_of_packet;
  logic       end_of_packet;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_done;
  logic [1:0] status;

  int pending;
  int mismatches;
  int bytes_checked;
  int cycle_count = 0;
  int in_gap_pct = 29;
  int out_gap_pct = 49;
  int beats_sent = 0;
  int settings_used = 0;

  always #5 clk = ~clk;

  dle_stx_packet_framer_crc8 u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .start_of_packet (start_of_packet),
    .end_of_packet   (end_of_packet),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .run_last        (run_last),
    .frame_done      (frame_done),
    .status          (status)
  );

  frame_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .start_of_packet (start_of_packet),
    .end_of_packet   (end_of_packet),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .run_last        (run_last),
    .frame_done      (frame_done),
    .status          (status),
    .pending         (pending),
    .mismatches      (mismatches),
    .bytes_checked   (bytes_checked)
  );

  // Receiver back-pressure at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_gap_pct);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Presents one payload beat, after random gaps, and holds it until taken.
  task automatic send_beat(input logic [7:0] d, input bit sop, input bit eop);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    data_byte       <= d;
    start_of_packet <= sop;
    end_of_packet   <= eop;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  // Holds the sender back until every predicted line beat has arrived, then
  // lets beats that cause no result work their way out of the block.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic [7:0] ptype, input logic [7:0] limit);
    cfg_we   <= 1'b1;
    cfg_addr <= REG_PACKET_TYPE;
    cfg_data <= ptype;
    @(posedge clk);
    cfg_addr <= REG_MAX_LENGTH;
    cfg_data <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // A packet of random bytes, rich in DLE; left open when close is clear.
  task automatic send_packet(input int len, input bit close);
    logic [7:0] d;
    for (int k = 0; k < len; k++) begin
      d = ($urandom_range(3) == 0) ? DLE_BYTE : 8'($urandom);
      send_beat(d, k == 0, close && (k == len - 1));
    end
  endtask

  // Mostly whole packets; some are abandoned by the next start, and a few
  // stray beats arrive between packets.
  task automatic random_traffic(input int budget);
    int used;
    int len;
    int pick;
    used = 0;
    while (used < budget) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_beat(8'($urandom), 1'b0, 1'($urandom_range(1)));
      end else begin
        len = ($urandom_range(7) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 6);
        send_packet(len, pick >= 16);
        used += len;
      end
    end
    send_packet(1, 1'b1);
  endtask

  initial begin
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_addr        <= REG_PACKET_TYPE;
    cfg_data        <= 8'h00;
    in_valid        <= 1'b0;
    data_byte       <= 8'h00;
    start_of_packet <= 1'b0;
    end_of_packet   <= 1'b0;
    out_stall       <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // DLE as the type byte, extreme data bytes and a stray beat while idle.
    set_regs(DLE_BYTE, 8'd255);
    send_beat(8'h55, 1'b0, 1'b0);
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(DLE_BYTE, 1'b0, 1'b0);
    send_beat(8'hAA, 1'b0, 1'b1);
    // A start while a packet is open abandons it.
    send_beat(8'h01, 1'b1, 1'b0);
    send_beat(8'h02, 1'b1, 1'b0);
    send_beat(8'h03, 1'b0, 1'b1);
    drain();

    // With a zero type byte this payload leaves a CRC equal to DLE.
    set_regs(8'h00, 8'd255);
    send_beat(8'hB3, 1'b1, 1'b1);
    drain();

    // Room for a data DLE but not its stuffed copy; the packet is then dropped
    // up to its end. The next packet runs out of room on the closing DLE.
    set_regs(8'h00, 8'd5);
    send_beat(8'h7E, 1'b1, 1'b0);
    send_beat(DLE_BYTE, 1'b0, 1'b0);
    send_beat(8'h11, 1'b0, 1'b0);
    send_beat(8'h22, 1'b0, 1'b1);
    send_beat(8'h44, 1'b1, 1'b1);
    drain();

    // Limits shorter than the header itself.
    set_regs(DLE_BYTE, 8'd3);
    send_beat(8'h5A, 1'b1, 1'b1);
    drain();
    set_regs(8'hFF, 8'd0);
    send_beat(8'hC3, 1'b1, 1'b1);
    send_beat(8'h3C, 1'b0, 1'b0);
    drain();

    // Random traffic: sender idles less than the receiver.
    set_regs(DLE_BYTE, 8'd4);
    random_traffic(6);
    drain();
    set_regs(8'($urandom), 8'($urandom_range(12, 40)));
    random_traffic(12);
    drain();

    // Receiver idles less than the sender.
    in_gap_pct  = 49;
    out_gap_pct = 29;
    set_regs(8'hFF, 8'd255);
    random_traffic(12);
    drain();
    set_regs(8'h00, 8'($urandom_range(4, 16)));
    random_traffic(6);
    drain();

    // Neither side idles.
    in_gap_pct  = 0;
    out_gap_pct = 0;
    set_regs(8'($urandom), 8'd255);
    random_traffic(12);
    drain();
    set_regs(8'($urandom), 8'($urandom_range(8, 30)));
    random_traffic(6);
    drain();

    $display("Sent %0d payload beats under %0d register settings; %0d line bytes compared.",
             beats_sent, settings_used, bytes_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ dle_stx_packet_framer_crc8.f @@
src/pfc_pkg.sv
src/pfc_queue.sv
src/pfc_engine.sv
src/dle_stx_packet_framer_crc8.sv
tb/frame_checker.sv
tb/tb_top.sv
